>>> design/wcg_pkg.sv
// wcg_pkg: shared widths, register indexes, window kinds and fixed-point constants
// for the window coefficient generator; no dependencies

package wcg_pkg;

    // field widths
    localparam int IDX_W     = 14;
    localparam int LEN_W     = 15;
    localparam int KIND_W    = 2;
    localparam int COEF_W    = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b1;

    // window kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HANN    = 2'd0,
        KIND_HAMMING = 2'd1,
        KIND_NUTTALL = 2'd2
    } window_kind_t;

    localparam logic [LEN_W-1:0] DEFAULT_LENGTH     = 15'd1024;
    localparam int unsigned      DEFAULT_MAX_LENGTH = 16384;

    // phase as a 24-bit fraction of a turn, three harmonic lanes
    localparam int PHASE_W   = 24;
    localparam int LANES     = 3;
    localparam int DIV_STEPS = PHASE_W;

    localparam logic [22:0] QUARTER_TURN = 23'h40_0000;
    localparam logic [21:0] EIGHTH_TURN  = 22'h20_0000;

    // Q30 arithmetic
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

    // series evaluation: five steps, divisor and 2^32/divisor (floor) per step
    localparam int HORNER_STEPS = 5;
    localparam logic [6:0]  COS_DIV [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [6:0]  SIN_DIV [HORNER_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
        32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648
    };
    localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };

    // window weights, Q30
    localparam logic [29:0] HANN_A0    = 30'd536870912;
    localparam logic [29:0] HAMMING_A0 = 30'd579820585;
    localparam logic [29:0] HAMMING_A1 = 30'd493921239;
    localparam logic [29:0] NUTTALL_A0 = 30'd382002981;
    localparam logic [29:0] NUTTALL_A1 = 30'd523337470;
    localparam logic [29:0] NUTTALL_A2 = 30'd154867931;
    localparam logic [29:0] NUTTALL_A3 = 30'd13533442;

    // pipeline latencies of the two sub-blocks
    localparam int PHASE_LAT = DIV_STEPS + 1;
    localparam int COS_LAT   = 4 * HORNER_STEPS + 5;

endpackage

>>> design/wcg_phase.sv
// wcg_phase: pipelined restoring divider giving the turn fraction m*i/D for m = 1..3
// depends on wcg_pkg

module wcg_phase (
    input  logic                             clk,
    input  logic [wcg_pkg::IDX_W-1:0]        idx,
    input  logic [wcg_pkg::LEN_W-1:0]        divisor,
    input  logic                             div_zero,
    output logic [wcg_pkg::PHASE_W-1:0]      phase [wcg_pkg::LANES]
);

    localparam int LW = wcg_pkg::LEN_W;
    localparam int PW = wcg_pkg::PHASE_W;
    localparam int NL = wcg_pkg::LANES;
    localparam int NS = wcg_pkg::DIV_STEPS;

    logic [LW-1:0] rem_reg [NS+1][NL];
    logic [PW-1:0] quo_reg [NS+1][NL];
    logic [LW-1:0] d_reg   [NS+1];
    logic          dz_reg  [NS+1];

    // integer part: for an in-range index m*i is at most 3*D, so at most two subtractions
    logic [15:0]   mi       [NL];
    logic [15:0]   d_x1;
    logic [15:0]   d_x2;
    logic [LW-1:0] rem_next [NL];

    assign mi[0] = {2'b00, idx};
    assign mi[1] = {1'b0, idx, 1'b0};
    assign mi[2] = {1'b0, idx, 1'b0} + {2'b00, idx};
    assign d_x1  = {1'b0, divisor};
    assign d_x2  = {divisor, 1'b0};

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (mi[l] >= d_x2)
            begin
                rem_next[l] = LW'(mi[l] - d_x2);
            end
            else if (mi[l] >= d_x1)
            begin
                rem_next[l] = LW'(mi[l] - d_x1);
            end
            else
            begin
                rem_next[l] = LW'(mi[l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            rem_reg[0][l] <= rem_next[l];
            quo_reg[0][l] <= '0;
        end
        d_reg[0]  <= divisor;
        dz_reg[0] <= div_zero;
    end

    // one fraction bit per stage
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            logic [LW:0]   shl;
            logic          ge;
            logic [LW-1:0] step_rem_next;
            logic [PW-1:0] step_quo_next;

            assign shl           = {rem_reg[k][l], 1'b0};
            assign ge            = shl >= {1'b0, d_reg[k]};
            assign step_rem_next = ge ? LW'(shl - {1'b0, d_reg[k]}) : LW'(shl);
            assign step_quo_next = {quo_reg[k][l][PW-2:0], ge};

            always_ff @(posedge clk)
            begin
                rem_reg[k+1][l] <= step_rem_next;
                quo_reg[k+1][l] <= step_quo_next;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[k+1]  <= d_reg[k];
            dz_reg[k+1] <= dz_reg[k];
        end
    end

    // a zero divisor means phase zero
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            phase[l] = dz_reg[NS] ? '0 : quo_reg[NS][l];
        end
    end

endmodule

>>> design/wcg_cos.sv
// wcg_cos: pipelined cosine of a 24-bit turn fraction, signed Q30 result
// octant fold plus truncated Taylor series; depends on wcg_pkg

module wcg_cos (
    input  logic                          clk,
    input  logic [wcg_pkg::PHASE_W-1:0]   phase,
    output logic signed [31:0]            cos_val
);

    localparam int H = wcg_pkg::HORNER_STEPS;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic        use_sin;
        logic        neg;
    } ctx_t;

    // fold to an octant
    logic [1:0]  quad;
    logic [21:0] frac;
    logic        past_eighth;
    logic [21:0] arg_next;
    logic [21:0] arg_reg;
    logic        fsin_reg;
    logic        fneg_reg;

    assign quad        = phase[23:22];
    assign frac        = phase[21:0];
    assign past_eighth = frac > wcg_pkg::EIGHTH_TURN;
    assign arg_next    = past_eighth ? 22'(wcg_pkg::QUARTER_TURN - {1'b0, frac}) : frac;

    always_ff @(posedge clk)
    begin
        arg_reg  <= arg_next;
        fsin_reg <= quad[0] ^ past_eighth;
        fneg_reg <= quad[0] ^ quad[1];
    end

    // octant position to radians
    logic [52:0] rad_prod;
    logic [29:0] x_reg;
    logic        rsin_reg;
    logic        rneg_reg;

    assign rad_prod = arg_reg * wcg_pkg::PI_HALF_Q30;

    always_ff @(posedge clk)
    begin
        x_reg    <= rad_prod[51:22];
        rsin_reg <= fsin_reg;
        rneg_reg <= fneg_reg;
    end

    // square, series starts from t = 1
    logic [59:0] sq_prod;
    ctx_t        ctx_t_reg [H+1];
    logic [30:0] t_reg     [H+1];

    assign sq_prod = x_reg * x_reg;

    always_ff @(posedge clk)
    begin
        ctx_t_reg[0] <= '{x: x_reg, x2: sq_prod[59:30], use_sin: rsin_reg, neg: rneg_reg};
        t_reg[0]     <= wcg_pkg::ONE_Q30;
    end

    // t = 1 - ((x2 * t) >> 30) / k, four stages per step
    for (genvar j = 0; j < H; j++)
    begin : g_horner
        logic [60:0] m_prod;
        ctx_t        ctx_m_reg;
        logic [29:0] v_m_reg;

        assign m_prod = ctx_t_reg[j].x2 * t_reg[j];

        always_ff @(posedge clk)
        begin
            ctx_m_reg <= ctx_t_reg[j];
            v_m_reg   <= m_prod[59:30];
        end

        // quotient estimate by reciprocal, low by at most one
        logic [31:0] rcp;
        logic [61:0] r_prod;
        ctx_t        ctx_r_reg;
        logic [29:0] v_r_reg;
        logic [29:0] qe_r_reg;

        assign rcp    = ctx_m_reg.use_sin ? wcg_pkg::SIN_RCP[j] : wcg_pkg::COS_RCP[j];
        assign r_prod = v_m_reg * rcp;

        always_ff @(posedge clk)
        begin
            ctx_r_reg <= ctx_m_reg;
            v_r_reg   <= v_m_reg;
            qe_r_reg  <= r_prod[61:32];
        end

        logic [6:0]  kdiv;
        logic [29:0] rem;
        ctx_t        ctx_c_reg;
        logic [29:0] qe_c_reg;
        logic        corr_c_reg;

        assign kdiv = ctx_r_reg.use_sin ? wcg_pkg::SIN_DIV[j] : wcg_pkg::COS_DIV[j];
        assign rem  = v_r_reg - 30'(qe_r_reg * kdiv);

        always_ff @(posedge clk)
        begin
            ctx_c_reg  <= ctx_r_reg;
            qe_c_reg   <= qe_r_reg;
            corr_c_reg <= rem >= {23'd0, kdiv};
        end

        logic [30:0] t_next;

        assign t_next = wcg_pkg::ONE_Q30 - {1'b0, qe_c_reg} - {30'd0, corr_c_reg};

        always_ff @(posedge clk)
        begin
            ctx_t_reg[j+1] <= ctx_c_reg;
            t_reg[j+1]     <= t_next;
        end
    end

    // sine takes one more factor of x
    logic [60:0] fin_prod;
    logic [30:0] mag_reg;
    logic        mneg_reg;

    assign fin_prod = ctx_t_reg[H].x * t_reg[H];

    always_ff @(posedge clk)
    begin
        mag_reg  <= ctx_t_reg[H].use_sin ? fin_prod[60:30] : t_reg[H];
        mneg_reg <= ctx_t_reg[H].neg;
    end

    logic signed [31:0] cos_reg;

    always_ff @(posedge clk)
    begin
        cos_reg <= mneg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    assign cos_val = cos_reg;

endmodule

>>> design/window_coefficient_generator.sv
// window_coefficient_generator: top level, Hann / Hamming / four-term Nuttall coefficients
// depends on wcg_pkg, wcg_phase, wcg_cos

// Streaming window coefficient generator. Every cycle in which start is high one
// sample index is taken (busy never rises); the coefficient for that index,
// unsigned Q1.16, appears on coefficient for one cycle with done high, together
// with index_out_of_range. Results come out in order, one per accepted index, at
// up to one per cycle; the receiver must take each one in the cycle it is shown.
// The longest parts of the pipeline are the 24-stage phase divider (one fraction
// bit per stage) and the cosine series pipeline (four stages per series term).
// Window kind and length are written through cfg_we / cfg_index / cfg_data and
// must only change while no index is in flight. Lengths above MAX_LENGTH act as
// MAX_LENGTH; a length of zero flags every index.

module window_coefficient_generator #(
    parameter int unsigned MAX_LENGTH = wcg_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [wcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcg_pkg::CFG_W-1:0]         cfg_data,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  logic [wcg_pkg::IDX_W-1:0]         sample_index,
    // result side
    output logic                              done,
    output logic [wcg_pkg::COEF_W-1:0]        coefficient,
    output logic                              index_out_of_range
);

    localparam int LW       = wcg_pkg::LEN_W;
    localparam int NL       = wcg_pkg::LANES;
    localparam int SIDE_LAT = wcg_pkg::PHASE_LAT + wcg_pkg::COS_LAT;

    // per-transfer control that rides alongside the datapath
    typedef struct packed {
        logic                       vld;
        logic                       oor;
        logic [wcg_pkg::KIND_W-1:0] kind;
    } side_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [wcg_pkg::KIND_W-1:0] kind_reg;
    logic [LW-1:0]              length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= wcg_pkg::KIND_HANN;
            length_reg <= wcg_pkg::DEFAULT_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wcg_pkg::REG_KIND:   kind_reg   <= cfg_data[wcg_pkg::KIND_W-1:0];
                wcg_pkg::REG_LENGTH: length_reg <= cfg_data[LW-1:0];
                default:             ;
            endcase
        end
    end

    // fully pipelined, a transfer is taken every cycle
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // input stage: effective length, range check, divisor choice
    // ---------------------------------------------------------------
    logic [LW-1:0] n_eff;
    logic          oor_next;
    logic [LW-1:0] div_next;

    assign n_eff    = (32'(length_reg) > MAX_LENGTH) ? LW'(MAX_LENGTH) : length_reg;
    assign oor_next = {1'b0, sample_index} >= n_eff;
    // Nuttall divides the turn by N, the two-term windows by N-1
    assign div_next = (kind_reg == wcg_pkg::KIND_NUTTALL) ? n_eff : n_eff - LW'(1);

    side_t                      side_reg [SIDE_LAT+1];
    logic [wcg_pkg::IDX_W-1:0]  idx_reg;
    logic [LW-1:0]              div_reg;
    logic                       dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else
        begin
            side_reg[0] <= '{vld: start && !busy, oor: oor_next, kind: kind_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= sample_index;
        div_reg <= div_next;
        dz_reg  <= div_next == '0;
    end

    // control delay line matching the phase and cosine pipelines
    for (genvar s = 0; s < SIDE_LAT; s++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s+1] <= '0;
            end
            else
            begin
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    // ---------------------------------------------------------------
    // phase of each harmonic, then its cosine
    // ---------------------------------------------------------------
    logic [wcg_pkg::PHASE_W-1:0] phase [NL];
    logic signed [31:0]          cosv  [NL];

    wcg_phase u_phase (
        .clk      (clk),
        .idx      (idx_reg),
        .divisor  (div_reg),
        .div_zero (dz_reg),
        .phase    (phase)
    );

    for (genvar l = 0; l < NL; l++)
    begin : g_cos
        wcg_cos u_cos (
            .clk     (clk),
            .phase   (phase[l]),
            .cos_val (cosv[l])
        );
    end

    // ---------------------------------------------------------------
    // weighting: one product per harmonic
    // ---------------------------------------------------------------
    logic [29:0]        a0;
    logic [29:0]        w1;
    logic [29:0]        w2;
    logic [29:0]        w3;

    always_comb
    begin
        case (side_reg[SIDE_LAT].kind)
            wcg_pkg::KIND_HANN:
            begin
                a0 = wcg_pkg::HANN_A0;
                w1 = wcg_pkg::HANN_A0;
                w2 = '0;
                w3 = '0;
            end
            wcg_pkg::KIND_HAMMING:
            begin
                a0 = wcg_pkg::HAMMING_A0;
                w1 = wcg_pkg::HAMMING_A1;
                w2 = '0;
                w3 = '0;
            end
            wcg_pkg::KIND_NUTTALL:
            begin
                a0 = wcg_pkg::NUTTALL_A0;
                w1 = wcg_pkg::NUTTALL_A1;
                w2 = wcg_pkg::NUTTALL_A2;
                w3 = wcg_pkg::NUTTALL_A3;
            end
            default:
            begin
                // unused kind gives a zero sum
                a0 = '0;
                w1 = '0;
                w2 = '0;
                w3 = '0;
            end
        endcase
    end

    logic signed [62:0] p1_next;
    logic signed [62:0] p2_next;
    logic signed [62:0] p3_next;

    assign p1_next = $signed({1'b0, w1}) * cosv[0];
    assign p2_next = $signed({1'b0, w2}) * cosv[1];
    assign p3_next = $signed({1'b0, w3}) * cosv[2];

    side_t              wgt_side_reg;
    logic [29:0]        a0_reg;
    logic signed [62:0] p1_reg;
    logic signed [62:0] p2_reg;
    logic signed [62:0] p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_side_reg <= '0;
        end
        else
        begin
            wgt_side_reg <= side_reg[SIDE_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg <= a0;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        p3_reg <= p3_next;
    end

    // ---------------------------------------------------------------
    // Q60 sum in two adder stages
    // ---------------------------------------------------------------
    logic signed [63:0] sa_next;
    logic signed [63:0] sb_next;

    assign sa_next = $signed({4'd0, a0_reg, 30'd0}) - 64'(p1_reg);
    assign sb_next = 64'(p2_reg) - 64'(p3_reg);

    side_t              sum1_side_reg;
    logic signed [63:0] sa_reg;
    logic signed [63:0] sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum1_side_reg <= '0;
        end
        else
        begin
            sum1_side_reg <= wgt_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        sb_reg <= sb_next;
    end

    side_t              sum2_side_reg;
    logic signed [63:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum2_side_reg <= '0;
        end
        else
        begin
            sum2_side_reg <= sum1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sa_reg + sb_reg;
    end

    // ---------------------------------------------------------------
    // output: round Q60 to Q16, clamp at zero and at 1.0
    // ---------------------------------------------------------------
    logic [63:0]                rounded;
    logic [19:0]                coef_wide;
    logic [wcg_pkg::COEF_W-1:0] coef_next;

    assign rounded   = $unsigned(sum_reg) + 64'h0000_0800_0000_0000;
    assign coef_wide = rounded[63:44];

    always_comb
    begin
        if (sum2_side_reg.oor || sum_reg <= 64'sd0)
        begin
            coef_next = '0;
        end
        else if (coef_wide > 20'd65536)
        begin
            coef_next = 17'd65536;
        end
        else
        begin
            coef_next = coef_wide[wcg_pkg::COEF_W-1:0];
        end
    end

    logic                       done_reg;
    logic [wcg_pkg::COEF_W-1:0] coef_reg;
    logic                       oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sum2_side_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        oor_reg  <= sum2_side_reg.oor;
    end

    assign done               = done_reg;
    assign coefficient        = coef_reg;
    assign index_out_of_range = oor_reg;

endmodule
